// File: src/lpht_pkg.sv
// Package for the linear probing hash table: request/response words,
// table geometry, slot status and outcome codes. No dependencies.
package lpht_pkg;

  // Table geometry (TABLE_SIZE must be a power of two: home slot is a mask)
  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int KIND_W     = 2;
  localparam int OUTC_W     = 3;
  localparam int SLOT_IDX_W = 6;
  localparam int STATUS_W   = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Slot status codes
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 2'd2;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUT_INSERTED  = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_DUPLICATE = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_FULL      = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_FOUND     = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_NOT_FOUND = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_DELETED   = 3'd5;

  // Request word
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } req_t;

  // Response word
  typedef struct packed {
    logic [OUTC_W-1:0]     outcome;
    logic [SLOT_IDX_W-1:0] slot_index;
  } rsp_t;

  // One table entry as stored in the slot RAM
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
  } entry_t;

endpackage

// File: src/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/linear_probing_hash_table.sv
// Linear probing hash table top level; uses lpht_pkg and lpht_ram.
// Each request probes P slots, P = 1..TABLE_SIZE; a probe is a slot RAM read
//   in S_READ, then a compare in S_EVAL, which holds while the response waits.
// Throughput: one request in flight; next request accepted once the response
//   is registered. Reset: synchronous rst empties all slots at once through
//   per-slot valid flops, no clearing pass.
module linear_probing_hash_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lpht_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lpht_pkg::rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  state_t state, state_next;

  logic [lpht_pkg::KIND_W-1:0]   kind_q;
  logic [lpht_pkg::KEY_W-1:0]    key_q;
  logic [lpht_pkg::IDX_W-1:0]    probe;
  logic [lpht_pkg::IDX_W-1:0]    count;
  logic [lpht_pkg::TABLE_SIZE-1:0] slot_valid;

  lpht_pkg::entry_t            rd_entry;
  logic [$bits(lpht_pkg::entry_t)-1:0] rd_raw;
  lpht_pkg::entry_t            wr_entry;
  logic [lpht_pkg::STATUS_W-1:0] cur_status;
  logic                        key_hit;
  logic                        last_probe;

  logic                        done;
  logic                        wr_req;
  logic [lpht_pkg::STATUS_W-1:0] wr_status;
  logic [lpht_pkg::OUTC_W-1:0] res_outcome;
  logic [lpht_pkg::IDX_W-1:0]  res_idx;
  logic                        fire;
  logic                        wr_en;
  logic                        accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Slot RAM: status and key of each slot
  assign wr_entry.status = wr_status;
  assign wr_entry.key    = key_q;
  assign rd_entry        = lpht_pkg::entry_t'(rd_raw);

  lpht_ram #(
    .WIDTH($bits(lpht_pkg::entry_t)),
    .DEPTH(lpht_pkg::TABLE_SIZE)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(probe),
    .wr_data(wr_entry),
    .rd_addr(probe),
    .rd_data(rd_raw)
  );

  // Slot that was never written reads as empty
  assign cur_status = slot_valid[probe] ? rd_entry.status : lpht_pkg::ST_EMPTY;
  assign key_hit    = (rd_entry.key == key_q);
  assign last_probe = (count == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1));

  // Probe decision for the slot just read
  always_comb begin
    done        = 1'b1;
    wr_req      = 1'b0;
    wr_status   = lpht_pkg::ST_OCCUPIED;
    res_outcome = lpht_pkg::OUT_NOT_FOUND;
    res_idx     = '0;
    priority if (kind_q == lpht_pkg::KIND_INSERT) begin
      priority if (cur_status == lpht_pkg::ST_EMPTY ||
                   cur_status == lpht_pkg::ST_DELETED) begin
        wr_req      = 1'b1;
        res_outcome = lpht_pkg::OUT_INSERTED;
        res_idx     = probe;
      end else if (key_hit) begin
        res_outcome = lpht_pkg::OUT_DUPLICATE;
        res_idx     = probe;
      end else if (last_probe) begin
        res_outcome = lpht_pkg::OUT_FULL;
      end else begin
        done = 1'b0;
      end
    end else if (kind_q == lpht_pkg::KIND_SEARCH ||
                 kind_q == lpht_pkg::KIND_DELETE) begin
      priority if (cur_status == lpht_pkg::ST_EMPTY) begin
        res_outcome = lpht_pkg::OUT_NOT_FOUND;
      end else if (key_hit) begin
        // tombstone with matching key ends the search as a miss
        if (cur_status != lpht_pkg::ST_DELETED) begin
          res_idx = probe;
          if (kind_q == lpht_pkg::KIND_DELETE) begin
            wr_req      = 1'b1;
            wr_status   = lpht_pkg::ST_DELETED;
            res_outcome = lpht_pkg::OUT_DELETED;
          end else begin
            res_outcome = lpht_pkg::OUT_FOUND;
          end
        end
      end else if (last_probe) begin
        res_outcome = lpht_pkg::OUT_NOT_FOUND;
      end else begin
        done = 1'b0;
      end
    end else begin
      // unused kind: ignored, answered as not found
      res_outcome = lpht_pkg::OUT_NOT_FOUND;
    end
  end

  assign fire  = (state == S_EVAL) && done && (!rsp_valid || rsp_ready);
  assign wr_en = fire && wr_req;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (!done) begin
          state_next = S_READ;
        end else if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and probe walk
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req.kind;
      key_q  <= req.key;
      probe  <= req.key[lpht_pkg::IDX_W-1:0];
      count  <= '0;
    end else if (state == S_EVAL && !done) begin
      probe <= probe + 1'b1;
      count <= count + 1'b1;
    end
  end

  // Per-slot written flags: reset empties the table
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[probe] <= 1'b1;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.outcome    <= res_outcome;
      rsp.slot_index <= lpht_pkg::SLOT_IDX_W'(res_idx);
    end
  end

  // Table writes only happen when a request completes
  a_write_at_eval: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_EVAL) && fire)
    else $error("slot write outside completion");

  // An accepted request starts a slot read
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("accepted request did not start a probe");

  // Unresolved probe advances to the next slot
  a_probe_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) && !done |=>
      (state == S_READ) && (probe == $past(probe) + 1'b1))
    else $error("probe did not advance");

  // A new response only comes out of the compare cycle
  a_rsp_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_EVAL))
    else $error("response raised outside compare cycle");

endmodule
